### rtl/flash_ring_log_pointer_manager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flash ring log pointer manager.
// Define ASSERT_OFF to compile every assertion away.
// ----------------------------------------------------------------------------
`ifndef FLASH_RING_LOG_POINTER_MANAGER_ASSERT_SVH
`define FLASH_RING_LOG_POINTER_MANAGER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define FRLPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRLPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FRLPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FRLPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/frlpm_pkg.sv
// ----------------------------------------------------------------------------
// frlpm_pkg
// Shared types, codes and sizes of the flash ring log pointer manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frlpm_pkg;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 12;
    localparam int CMD_W       = 2;
    localparam int ACT_W       = 2;

    localparam int PAGE_BYTES_DEFAULT = 2048;
    localparam int PAGE_COUNT_DEFAULT = 8;

    // Most flash commands one request can cause, and depth of the result queue.
    localparam int MAX_RESULTS = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    // Request actions
    localparam logic [ACT_W-1:0] ACT_STORE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ_NEXT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP_READ = 2'd2;

    // Flash commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LEN_W-1:0] record_length;
    } req_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] flash_address;
        logic [LEN_W-1:0]  byte_count;
        logic              last;
    } rsp_t;

    typedef logic [ADDR_W-1:0] cfg_t;

    // All results of one request, in order; n of them are valid.
    typedef struct packed {
        logic [N_W-1:0]               n;
        rsp_t [MAX_RESULTS-1:0]       item;
    } batch_t;

endpackage

### rtl/frlpm_chan_if.sv
// ----------------------------------------------------------------------------
// frlpm_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frlpm_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

### rtl/frlpm_core.sv
// ----------------------------------------------------------------------------
// frlpm_core
// Request register, log pointers and flash command generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_ring_log_pointer_manager_assert.svh"

module frlpm_core #(
    parameter int PAGE_BYTES = frlpm_pkg::PAGE_BYTES_DEFAULT,
    parameter int PAGE_COUNT = frlpm_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    frlpm_chan_if.sink                  req,
    input  logic [frlpm_pkg::ADDR_W-1:0] log_base,
    input  logic                        room_ok,
    output logic                        fire,
    output frlpm_pkg::batch_t           batch
);

    localparam int OFS_W   = $clog2(PAGE_BYTES);
    localparam int SPAN_W  = $clog2(PAGE_BYTES + 1);
    localparam int CW      = (SPAN_W > frlpm_pkg::LEN_W) ? SPAN_W : frlpm_pkg::LEN_W;
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [CW-1:0]     PAGE_LEN  = CW'(PAGE_BYTES);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

    localparam logic [1:0] PH_STOPPED = 2'd0;
    localparam logic [1:0] PH_RUNNING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    function automatic logic [frlpm_pkg::ADDR_W-1:0] page_addr(
        input logic [frlpm_pkg::ADDR_W-1:0] base,
        input logic [PAGE_W-1:0]            page
    );
        return base + frlpm_pkg::ADDR_W'(page) * frlpm_pkg::ADDR_W'(PAGE_BYTES);
    endfunction

    function automatic logic [PAGE_W-1:0] next_page(input logic [PAGE_W-1:0] page);
        return (page == LAST_PAGE) ? '0 : page + 1'b1;
    endfunction

    frlpm_pkg::req_t   item_reg;
    logic              item_valid_reg, item_valid_next;

    logic [OFS_W-1:0]  wofs_reg, wofs_next;
    logic [PAGE_W-1:0] tail_reg, tail_next;
    logic [PAGE_W-1:0] head_reg, head_next;
    logic              wrapped_reg, wrapped_next;
    logic [PAGE_W-1:0] rpage_reg, rpage_next;
    logic [1:0]        phase_reg, phase_next;

    logic [CW-1:0]     len_sat;
    logic [CW-1:0]     room;
    logic [CW-1:0]     rem;
    logic [CW-1:0]     wofs_wide;
    logic [PAGE_W-1:0] ntail;
    logic [PAGE_W-1:0] rp;
    logic [frlpm_pkg::ADDR_W-1:0] tail_base, ntail_base, rp_base;

    logic accept;

    assign fire            = item_valid_reg & room_ok;
    assign req.ready       = ~item_valid_reg | room_ok;
    assign accept          = req.valid & req.ready;
    assign item_valid_next = accept | (item_valid_reg & ~fire);

    always_comb
    begin
        len_sat   = (CW'(item_reg.record_length) > PAGE_LEN) ?
                    PAGE_LEN : CW'(item_reg.record_length);
        wofs_wide = CW'(wofs_reg);
        room      = PAGE_LEN - wofs_wide;
        rem       = len_sat - room;
        ntail     = next_page(tail_reg);
        rp        = (phase_reg == PH_STOPPED) ? head_reg : rpage_reg;
        tail_base = page_addr(log_base, tail_reg);
        ntail_base = page_addr(log_base, ntail);
        rp_base   = page_addr(log_base, rp);

        wofs_next    = wofs_reg;
        tail_next    = tail_reg;
        head_next    = head_reg;
        wrapped_next = wrapped_reg;
        rpage_next   = rpage_reg;
        phase_next   = phase_reg;
        batch        = '0;

        if (fire)
        begin
            unique case (item_reg.action)
                frlpm_pkg::ACT_STORE:
                begin
                    if (len_sat != '0)
                    begin
                        if (len_sat < room)
                        begin
                            batch.item[0] = '{frlpm_pkg::CMD_WRITE,
                                              tail_base + frlpm_pkg::ADDR_W'(wofs_reg),
                                              len_sat[frlpm_pkg::LEN_W-1:0], 1'b1};
                            batch.n   = frlpm_pkg::N_W'(1);
                            wofs_next = wofs_reg + OFS_W'(len_sat);
                        end
                        else
                        begin
                            // Fill the page, move to the next one and erase it.
                            batch.item[0] = '{frlpm_pkg::CMD_WRITE,
                                              tail_base + frlpm_pkg::ADDR_W'(wofs_reg),
                                              room[frlpm_pkg::LEN_W-1:0], 1'b0};
                            batch.item[1] = '{frlpm_pkg::CMD_ERASE, ntail_base,
                                              PAGE_LEN[frlpm_pkg::LEN_W-1:0], 1'b0};
                            tail_next    = ntail;
                            wrapped_next = wrapped_reg | (ntail == '0);
                            if (wrapped_next)
                            begin
                                head_next = next_page(head_reg);
                            end
                            wofs_next = OFS_W'(rem);
                            if (rem != '0)
                            begin
                                batch.item[2] = '{frlpm_pkg::CMD_WRITE, ntail_base,
                                                  rem[frlpm_pkg::LEN_W-1:0], 1'b1};
                                batch.n = frlpm_pkg::N_W'(3);
                            end
                            else
                            begin
                                batch.item[1].last = 1'b1;
                                batch.n = frlpm_pkg::N_W'(2);
                            end
                        end
                    end
                end
                frlpm_pkg::ACT_READ_NEXT:
                begin
                    batch.n = frlpm_pkg::N_W'(1);
                    if (phase_reg == PH_STOPPED)
                    begin
                        rpage_next = head_reg;
                    end
                    if (phase_reg == PH_STOPPED || phase_reg == PH_RUNNING)
                    begin
                        phase_next = PH_RUNNING;
                        if (rp != tail_reg)
                        begin
                            batch.item[0] = '{frlpm_pkg::CMD_READ, rp_base,
                                              PAGE_LEN[frlpm_pkg::LEN_W-1:0], 1'b1};
                            rpage_next = next_page(rp);
                        end
                        else
                        begin
                            if (wofs_reg != '0)
                            begin
                                batch.item[0] = '{frlpm_pkg::CMD_READ, tail_base,
                                                  wofs_wide[frlpm_pkg::LEN_W-1:0], 1'b1};
                            end
                            else
                            begin
                                batch.item[0] = '{frlpm_pkg::CMD_NONE, '0, '0, 1'b1};
                            end
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        batch.item[0] = '{frlpm_pkg::CMD_NONE, '0, '0, 1'b1};
                    end
                end
                frlpm_pkg::ACT_STOP_READ:
                begin
                    phase_next = PH_STOPPED;
                end
                default:
                begin
                    // unused action: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            wofs_reg       <= '0;
            tail_reg       <= '0;
            head_reg       <= '0;
            wrapped_reg    <= 1'b0;
            rpage_reg      <= '0;
            phase_reg      <= PH_STOPPED;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            wofs_reg       <= wofs_next;
            tail_reg       <= tail_next;
            head_reg       <= head_next;
            wrapped_reg    <= wrapped_next;
            rpage_reg      <= rpage_next;
            phase_reg      <= phase_next;
        end
    end

    `FRLPM_ASSERT_IMPL(a_head_parked, clk, rst_n, !wrapped_reg, head_reg == '0,
        "head page moved before the ring wrapped")
    `FRLPM_ASSERT_IMPL(a_last_marked, clk, rst_n, fire && batch.n != '0,
        batch.item[batch.n - 1'b1].last, "final result of a request lacks last")
    `FRLPM_ASSERT_NEXT(a_item_held, clk, rst_n, item_valid_reg && !room_ok,
        item_valid_reg && $stable(item_reg), "pending request lost while queue full")

endmodule

### rtl/frlpm_rsp_queue.sv
// ----------------------------------------------------------------------------
// frlpm_rsp_queue
// Small result queue: takes up to three results at once, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_ring_log_pointer_manager_assert.svh"

module frlpm_rsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  frlpm_pkg::batch_t batch,
    output logic              room_ok,
    frlpm_chan_if.source      rsp
);

    frlpm_pkg::rsp_t                   mem_reg [frlpm_pkg::Q_DEPTH];
    logic [frlpm_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [frlpm_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [frlpm_pkg::Q_CNT_W-1:0]     count_reg, count_next;
    logic [frlpm_pkg::Q_CNT_W-1:0]     n_push;
    logic                              pop;

    assign rsp.valid   = (count_reg != '0);
    assign rsp.payload = mem_reg[rd_ptr_reg];
    assign pop         = rsp.valid & rsp.ready;

    // Space for a full batch, not counting a pop in this cycle.
    assign room_ok = (count_reg <= frlpm_pkg::Q_CNT_W'(frlpm_pkg::Q_DEPTH -
                                                        frlpm_pkg::MAX_RESULTS));

    assign n_push      = push ? frlpm_pkg::Q_CNT_W'(batch.n) : '0;
    assign wr_ptr_next = wr_ptr_reg + frlpm_pkg::Q_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + frlpm_pkg::Q_PTR_W'(pop);
    assign count_next  = count_reg + n_push - frlpm_pkg::Q_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < frlpm_pkg::MAX_RESULTS; k++)
        begin
            if (push && (frlpm_pkg::N_W'(k) < batch.n))
            begin
                mem_reg[wr_ptr_reg + frlpm_pkg::Q_PTR_W'(k)] <= batch.item[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `FRLPM_ASSERT_IMPL(a_ptr_count, clk, rst_n, 1'b1,
        frlpm_pkg::Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) ==
        frlpm_pkg::Q_PTR_W'(count_reg), "queue pointers disagree with fill count")
    `FRLPM_ASSERT_IMPL(a_no_overflow, clk, rst_n, push,
        room_ok, "batch pushed without room")
    `FRLPM_ASSERT_NEXT(a_hold_stalled, clk, rst_n, rsp.valid && !rsp.ready,
        rsp.valid && $stable(rsp.payload), "stalled result changed")

endmodule

### rtl/flash_ring_log_pointer_manager.sv
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager
// Log pointer keeper for a ring of flash pages; emits flash commands.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request items (action, record_length). Store writes a record at
//          the tail, read_next yields the next readout chunk, stop_read
//          resets the readout. Accepted when valid and ready are high.
//   rsp  : flash command items (command, flash_address, byte_count, last);
//          last marks the final command caused by one request.
//   cfg  : write of log_base_address, always ready; write only while idle.
// Path: a request's commands pass through the request register, then the
//   result queue, before they can be taken on rsp.
// Throughput: one request per cycle while each causes one command and rsp
//   is not stalled; a store that crosses a page end causes up to three
//   commands, and the single result port then sets the pace.
// Stall: the four-entry result queue holds the commands; the request
//   register holds a request until the queue has room for a full batch,
//   and req.ready drops while the register is full and the queue lacks room.
// Reset: pointers return to an empty ring at page 0, readout stopped,
//   base address zero, queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flash_ring_log_pointer_manager #(
    parameter int PAGE_BYTES = frlpm_pkg::PAGE_BYTES_DEFAULT,
    parameter int PAGE_COUNT = frlpm_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    frlpm_chan_if.sink   req,
    frlpm_chan_if.source rsp,
    frlpm_chan_if.sink   cfg
);

    logic [frlpm_pkg::ADDR_W-1:0] log_base_reg;
    logic                         room_ok;
    logic                         fire;
    frlpm_pkg::batch_t            batch;

    // Register writes never stall.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            log_base_reg <= cfg.payload;
        end
    end

    // Hold the request, update the pointers and build the command batch.
    frlpm_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .log_base (log_base_reg),
        .room_ok  (room_ok),
        .fire     (fire),
        .batch    (batch)
    );

    // Queue the batch and hand commands out one per handshake.
    frlpm_rsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .batch   (batch),
        .room_ok (room_ok),
        .rsp     (rsp)
    );

endmodule
